[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the string-literal decoder.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk, idle during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle form: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[rtl/msld_pkg.sv]
// Types, character constants and re-escaping functions of the string-literal decoder.
// Stands alone; used by mangled_string_literal_decoder.
`timescale 1ns / 1ps

package msld_pkg;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] LOWER_BASE = 8'hE1;
  localparam logic [7:0] UPPER_BASE = 8'hC1;

  localparam logic [15:0] U_TAB  = 16'h0009;
  localparam logic [15:0] U_LF   = 16'h000A;
  localparam logic [15:0] U_CR   = 16'h000D;
  localparam logic [15:0] U_BSL  = 16'h005C;
  localparam logic [15:0] U_SP   = 16'h0020;
  localparam logic [15:0] U_DEL  = 16'h007F;
  localparam logic [15:0] U_BMAX = 16'h00FF;

  // One decoded code unit after re-escaping: up to four characters.
  typedef struct packed {
    logic [1:0]       last_idx;
    logic             eos;
    logic [3:0][15:0] chars;
  } run_t;

  function automatic logic [7:0] punct_byte(input logic [3:0] d);
    logic [7:0] b;
    unique case (d)
      4'd0:    b = 8'h2C;
      4'd1:    b = 8'h2F;
      4'd2:    b = 8'h5C;
      4'd3:    b = 8'h3A;
      4'd4:    b = 8'h2E;
      4'd5:    b = 8'h20;
      4'd6:    b = 8'h0A;
      4'd7:    b = 8'h09;
      4'd8:    b = 8'h27;
      4'd9:    b = 8'h2D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] hex_char(input logic [3:0] n);
    logic [15:0] c;
    if (n < 4'd10) begin
      c = {8'h00, 4'h3, n};
    end else begin
      c = {8'h00, 4'h4, n - 4'd9};
    end
    return c;
  endfunction

  function automatic run_t encode_unit(input logic [15:0] u);
    run_t r;
    r.eos      = 1'b0;
    r.last_idx = 2'd0;
    r.chars    = '0;
    r.chars[0] = {8'h00, CH_BSL};
    if (u == U_TAB) begin
      r.chars[1] = {8'h00, CH_LT};
      r.last_idx = 2'd1;
    end else if (u == U_LF) begin
      r.chars[1] = {8'h00, CH_LN};
      r.last_idx = 2'd1;
    end else if (u == U_CR) begin
      r.chars[1] = {8'h00, CH_LR};
      r.last_idx = 2'd1;
    end else if (u == U_BSL) begin
      r.chars[1] = {8'h00, CH_BSL};
      r.last_idx = 2'd1;
    end else if (u < U_SP || (u > U_DEL && u <= U_BMAX)) begin
      r.chars[1] = {8'h00, CH_LX};
      r.chars[2] = hex_char(u[7:4]);
      r.chars[3] = hex_char(u[3:0]);
      r.last_idx = 2'd3;
    end else begin
      r.chars[0] = u;
    end
    return r;
  endfunction

endpackage

[rtl/mangled_string_literal_decoder.sv]
// Decoder for the body of a mangled string literal, with re-escaping of each code unit.
// Depends on msld_pkg and on assert_macros.svh.
`timescale 1ns / 1ps
// The run that a word re-escapes to is written into the run buffer at the edge that takes the word.
// Throughput: one input word per cycle while each yields at most one character and out_stall
// is low; a word that re-escapes to several characters holds the output until its run is
// drained by the one-character-per-cycle output serializer behind a two-entry run buffer.
// Reset (synchronous, rst_n low) clears decode state, wide mode and the run buffer.

`include "assert_macros.svh"

module mangled_string_literal_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char,
  output logic        out_char_valid,
  output logic        out_end_of_string,
  output logic        out_last_of_run
);

  // Configuration and decode state. Decode state is updated at the edge that takes an input
  // word, so the next word sees it at once; wide mode is updated when cfg_wr_en is high.
  logic       wide_r;
  logic       esc_r, esc_nxt;
  logic [1:0] hex_left_r, hex_left_nxt;
  logic [7:0] hex_acc_r, hex_acc_nxt;
  logic       hi_pend_r, hi_pend_nxt;
  logic [7:0] hi_byte_r, hi_byte_nxt;

  // Two-entry buffer of re-escaped runs and the serializer index into the head run.
  msld_pkg::run_t slot_r [2];
  logic       head_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;

  logic           in_acc, out_acc, push, pop;
  logic           has_out;
  msld_pkg::run_t run_nxt;
  msld_pkg::run_t head_run;
  logic           tail;

  // Byte delivery from the escape decoder toward the unit assembler.
  logic       dlv;
  logic [7:0] dlv_byte;
  logic [7:0] c_minus_a;
  logic [7:0] c_minus_la;
  logic       make_eos;
  logic [15:0] unit;
  logic        unit_ready;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // The input side stalls only when both run entries are occupied.
  assign in_stall  = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);

  assign c_minus_a  = in_char - msld_pkg::CH_UA;
  assign c_minus_la = in_char - msld_pkg::CH_LA;

  // Escape decoding. A pending '?$' digit or escape consumes the character whatever
  // it is, '@' included; only a bare '@' ends the string.
  always_comb begin
    esc_nxt      = esc_r;
    hex_left_nxt = hex_left_r;
    hex_acc_nxt  = hex_acc_r;
    dlv          = 1'b0;
    dlv_byte     = 8'h00;
    make_eos     = 1'b0;
    if (hex_left_r == 2'd2) begin
      hex_acc_nxt  = {c_minus_a[3:0], 4'h0};
      hex_left_nxt = 2'd1;
    end else if (hex_left_r == 2'd1) begin
      hex_left_nxt = 2'd0;
      dlv          = 1'b1;
      dlv_byte     = hex_acc_r + c_minus_a;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      dlv     = 1'b1;
      if (in_char >= msld_pkg::CH_LA && in_char <= msld_pkg::CH_LZ) begin
        dlv_byte = msld_pkg::LOWER_BASE + c_minus_la;
      end else if (in_char >= msld_pkg::CH_UA && in_char <= msld_pkg::CH_UZ) begin
        dlv_byte = msld_pkg::UPPER_BASE + c_minus_a;
      end else if (in_char == msld_pkg::CH_DOLLAR) begin
        dlv          = 1'b0;
        hex_left_nxt = 2'd2;
      end else if (in_char >= msld_pkg::CH_D0 && in_char <= msld_pkg::CH_D9) begin
        dlv_byte = msld_pkg::punct_byte(in_char[3:0]);
      end else begin
        // An unknown escape decodes as a zero byte.
        dlv_byte = 8'h00;
      end
    end else if (in_char == msld_pkg::CH_AT) begin
      make_eos = 1'b1;
    end else if (in_char == msld_pkg::CH_QMARK) begin
      esc_nxt = 1'b1;
    end else begin
      dlv      = 1'b1;
      dlv_byte = in_char;
    end
  end

  // Unit assembly. In wide mode the first byte is held as the high half; a byte taken in
  // narrow mode always forms a unit by itself and drops any held high byte.
  always_comb begin
    hi_pend_nxt = hi_pend_r;
    hi_byte_nxt = hi_byte_r;
    unit        = {8'h00, dlv_byte};
    unit_ready  = 1'b0;
    if (make_eos) begin
      hi_pend_nxt = 1'b0;
      hi_byte_nxt = 8'h00;
    end else if (dlv) begin
      if (wide_r && !hi_pend_r) begin
        hi_byte_nxt = dlv_byte;
        hi_pend_nxt = 1'b1;
      end else begin
        hi_pend_nxt = 1'b0;
        unit_ready  = 1'b1;
        if (wide_r) begin
          unit = {hi_byte_r, dlv_byte};
        end
      end
    end
  end

  // Re-escaping into a run; a zero unit yields nothing, the end marker yields one entry.
  always_comb begin
    run_nxt = msld_pkg::encode_unit(unit);
    has_out = unit_ready && (unit != 16'h0000);
    if (make_eos) begin
      run_nxt          = '0;
      run_nxt.eos      = 1'b1;
      has_out          = 1'b1;
    end
  end

  assign push     = in_acc && has_out;
  assign head_run = slot_r[head_r];
  assign pop      = out_acc && (idx_r == head_run.last_idx);
  assign tail     = head_r ^ cnt_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r     <= 1'b0;
      esc_r      <= 1'b0;
      hex_left_r <= 2'd0;
      hex_acc_r  <= 8'h00;
      hi_pend_r  <= 1'b0;
      hi_byte_r  <= 8'h00;
      head_r     <= 1'b0;
      cnt_r      <= 2'd0;
      idx_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        wide_r <= cfg_wr_data;
      end
      if (in_acc) begin
        esc_r      <= esc_nxt;
        hex_left_r <= hex_left_nxt;
        hex_acc_r  <= make_eos ? 8'h00 : hex_acc_nxt;
        hi_pend_r  <= hi_pend_nxt;
        hi_byte_r  <= hi_byte_nxt;
      end
      if (out_acc) begin
        idx_r <= pop ? 2'd0 : idx_r + 2'd1;
      end
      if (pop) begin
        head_r <= ~head_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Run storage is payload only; the count says which entries hold data.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail] <= run_nxt;
    end
  end

  assign out_char          = head_run.chars[idx_r];
  assign out_char_valid    = !head_run.eos;
  assign out_end_of_string = head_run.eos;
  assign out_last_of_run   = (idx_r == head_run.last_idx);

  `ASSERT_CLK(a_cnt_bound, cnt_r <= 2'd2, "run buffer count beyond its two entries")
  `ASSERT_IMPL(a_idx_in_run, out_valid, idx_r <= head_run.last_idx, "serializer index past run")
  `ASSERT_IMPL(a_eos_single, out_valid && out_end_of_string,
               out_last_of_run && idx_r == 2'd0, "end marker is not a one-entry run")
  `ASSERT_NEXT(a_push_shows, push && cnt_r == 2'd0, out_valid, "pushed run not presented")

endmodule
